// File: src/period_frequency_meter_7seg_assert.svh
// assertion macros used by the frequency meter controller
`ifndef PERIOD_FREQUENCY_METER_7SEG_ASSERT_SVH
`define PERIOD_FREQUENCY_METER_7SEG_ASSERT_SVH

// condition in the same cycle implies consequence in the same cycle
`define PFM7_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition in one cycle implies consequence in the next cycle
`define PFM7_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/pfm7_pkg.sv
// shared constants, types and helper functions of the frequency meter
package pfm7_pkg;

  // default width of the sample counter
  localparam int unsigned COUNT_BITS_DEF = 20;

  // sample period register
  localparam int unsigned PERIOD_W = 16;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd770;

  // reciprocal division: 1e8 hundredths-of-hertz microseconds
  localparam int unsigned DIVIDEND_W = 27;
  localparam logic [DIVIDEND_W-1:0] DIVIDEND = 27'd100000000;
  localparam int unsigned STEP_W = $clog2(DIVIDEND_W);

  // a divisor at or below this limit gives a quotient above the display range
  localparam int unsigned OVF_LIMIT = 10000;

  // displayed value and digits
  localparam int unsigned VAL_W = 14;
  localparam logic [VAL_W-1:0] MAX_DISPLAY = 14'd9999;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned NUM_DIGITS = 4;
  localparam int unsigned POS_W = 2;

  // divide by ten through a reciprocal, exact for every value below 2^14
  localparam int unsigned RECIP_W = 16;
  localparam logic [RECIP_W-1:0] RECIP_10 = 16'd52429;
  localparam int unsigned RECIP_SHIFT = 19;

  // digit position codes
  localparam logic [POS_W-1:0] POS_TENS       = 2'd0;
  localparam logic [POS_W-1:0] POS_ONES       = 2'd1;
  localparam logic [POS_W-1:0] POS_TENTHS     = 2'd2;
  localparam logic [POS_W-1:0] POS_HUNDREDTHS = 2'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic cnt_inc;     // count one sample, saturating
    logic mul_load;    // form period * count, clear the count
    logic div_init;    // start the reciprocal division
    logic div_step;    // one quotient bit
    logic sat_load;    // load the clamped value for digit split
    logic split_step;  // peel off one decimal digit
    logic emit_next;   // current digit transaction done
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic div_last;
    logic split_last;
    logic pos_last;
  } dp_status_t;

  // seven-segment pattern, bit0 segment a to bit6 segment g
  function automatic logic [6:0] seg_code(input logic [DIGIT_W-1:0] d);
    logic [6:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h3F;
    endcase
    return s;
  endfunction

endpackage

// File: src/period_frequency_meter_7seg.sv
// sequence: after the final high sample the block forms the product, runs the divider and splits
//   the digits, then emits one digit per cycle while out_ready is high
// throughput: one level sample per cycle while idle; a finished period holds input through the
//   arithmetic, dominated by the 27-step serial reciprocal divider, and 3 or 4 digit transactions
// reset: synchronous, active high; clears the phase, count and sequencer, period back to 770
module period_frequency_meter_7seg #(
  parameter int unsigned COUNT_BITS = pfm7_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pfm7_pkg::PERIOD_W-1:0] sample_period_us,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [6:0]                    segments,
  output logic                          decimal_point,
  output logic [pfm7_pkg::POS_W-1:0]    digit_position,
  output logic                          overflow,
  output logic                          last
);
  import pfm7_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // configuration writes land at any time
  assign cfg_ready = 1'b1;

  pfm7_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .level     (level),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  pfm7_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_valid),
    .cfg_data       (sample_period_us),
    .cmd            (cmd),
    .status         (status),
    .segments       (segments),
    .decimal_point  (decimal_point),
    .digit_position (digit_position),
    .overflow       (overflow),
    .last           (last)
  );

endmodule

// File: src/pfm7_dp.sv
// datapath: sample counter, period product, serial divider, digit split
module pfm7_dp #(
  parameter int unsigned COUNT_BITS = pfm7_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pfm7_pkg::PERIOD_W-1:0]    cfg_data,
  input  pfm7_pkg::ctrl_cmd_t              cmd,
  output pfm7_pkg::dp_status_t             status,
  output logic [6:0]                       segments,
  output logic                             decimal_point,
  output logic [pfm7_pkg::POS_W-1:0]       digit_position,
  output logic                             overflow,
  output logic                             last
);
  import pfm7_pkg::*;

  localparam int unsigned PROD_W = PERIOD_W + COUNT_BITS;
  localparam int unsigned CMP_W  = (DIVIDEND_W + 1 > PROD_W) ? DIVIDEND_W + 1 : PROD_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [PROD_W-1:0] OVF_LIM = PROD_W'(OVF_LIMIT);
  localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(DIVIDEND_W - 1);

  logic [PERIOD_W-1:0]   period;
  logic [COUNT_BITS-1:0] count;
  logic [PROD_W-1:0]     product;
  logic [DIVIDEND_W-1:0] rem;
  logic [DIVIDEND_W-1:0] quot;
  logic [STEP_W-1:0]     step_idx;
  logic                  ovf;
  logic [VAL_W-1:0]      val;
  logic [DIGIT_W-1:0]    digits [NUM_DIGITS];
  logic [POS_W-1:0]      dig_idx;
  logic [POS_W-1:0]      pos;

  // divider step: shift in the next dividend bit, subtract when it fits
  logic [DIVIDEND_W:0]   trial;
  logic [CMP_W-1:0]      trial_ext;
  logic [CMP_W-1:0]      diff;
  logic                  fits;

  always_comb begin
    trial     = {rem, quot[DIVIDEND_W-1]};
    trial_ext = CMP_W'(trial);
    fits      = trial_ext >= CMP_W'(product);
    diff      = trial_ext - CMP_W'(product);
  end

  // digit split: quotient and remainder by ten
  logic [VAL_W+RECIP_W-1:0] q_full;
  logic [VAL_W-1:0]         q10;
  logic [VAL_W-1:0]         ten_q;
  logic [DIGIT_W-1:0]       r10;

  always_comb begin
    q_full = (VAL_W+RECIP_W)'(val) * (VAL_W+RECIP_W)'(RECIP_10);
    q10    = VAL_W'(q_full >> RECIP_SHIFT);
    ten_q  = (q10 << 3) + (q10 << 1);
    r10    = DIGIT_W'(val - ten_q);
  end

  // sample period register
  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_RESET;
    end else if (cfg_we) begin
      period <= cfg_data;
    end
  end

  // saturating sample counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.mul_load) begin
      count <= '0;
    end else if (cmd.cnt_inc && count != COUNT_MAX) begin
      count <= count + 1'b1;
    end
  end

  // period product and divider
  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      product <= PROD_W'(period) * PROD_W'(count);
    end
    if (cmd.div_init) begin
      rem  <= '0;
      quot <= DIVIDEND;
      ovf  <= product <= OVF_LIM;
    end else if (cmd.div_step) begin
      rem  <= fits ? diff[DIVIDEND_W-1:0] : trial[DIVIDEND_W-1:0];
      quot <= {quot[DIVIDEND_W-2:0], fits};
    end
    if (cmd.sat_load) begin
      val <= ovf ? MAX_DISPLAY : quot[VAL_W-1:0];
    end else if (cmd.split_step) begin
      val <= q10;
      digits[dig_idx] <= r10;
    end
  end

  // step and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      step_idx <= '0;
      dig_idx  <= '0;
      pos      <= POS_TENS;
    end else begin
      if (cmd.div_init) begin
        step_idx <= STEP_FIRST;
      end else if (cmd.div_step) begin
        step_idx <= step_idx - 1'b1;
      end
      if (cmd.sat_load) begin
        dig_idx <= POS_HUNDREDTHS;
      end else if (cmd.split_step) begin
        dig_idx <= dig_idx - 1'b1;
        // a zero tens digit is skipped
        if (dig_idx == POS_TENS) begin
          pos <= (r10 == '0) ? POS_ONES : POS_TENS;
        end
      end else if (cmd.emit_next) begin
        pos <= pos + 1'b1;
      end
    end
  end

  // status to the controller
  always_comb begin
    status.div_last   = step_idx == '0;
    status.split_last = dig_idx == POS_TENS;
    status.pos_last   = pos == POS_HUNDREDTHS;
  end

  // result payload
  assign segments       = seg_code(digits[pos]);
  assign decimal_point  = pos == POS_ONES;
  assign digit_position = pos;
  assign overflow       = ovf;
  assign last           = pos == POS_HUNDREDTHS;

endmodule

// File: src/pfm7_ctrl.sv
// controller: level phase tracking and measurement sequencing
`include "period_frequency_meter_7seg_assert.svh"

module pfm7_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 level,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  pfm7_pkg::dp_status_t status,
  output pfm7_pkg::ctrl_cmd_t  cmd
);
  import pfm7_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL   = 7'b0000010,
    S_PREP  = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_SAT   = 7'b0010000,
    S_SPLIT = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  typedef enum logic [3:0] {
    PH_WAIT_LOW = 4'b0001,
    PH_ARMED    = 4'b0010,
    PH_HIGH     = 4'b0100,
    PH_LOW      = 4'b1000
  } phase_t;

  state_t state, state_next;
  phase_t phase, phase_next;
  logic   in_fire;
  logic   finish;
  logic   cnt_inc;

  assign in_ready  = state == S_IDLE;
  assign out_valid = state == S_EMIT;
  assign in_fire   = in_valid && in_ready;

  // level phase tracking and sample counting
  always_comb begin
    phase_next = phase;
    cnt_inc    = 1'b0;
    finish     = 1'b0;
    if (in_fire) begin
      case (phase)
        PH_WAIT_LOW: begin
          if (!level) phase_next = PH_ARMED;
        end
        PH_ARMED: begin
          if (level) begin
            phase_next = PH_HIGH;
            cnt_inc    = 1'b1;
          end
        end
        PH_HIGH: begin
          if (!level) phase_next = PH_LOW;
          cnt_inc = 1'b1;
        end
        PH_LOW: begin
          if (level) begin
            phase_next = PH_WAIT_LOW;
            finish     = 1'b1;
          end else begin
            cnt_inc = 1'b1;
          end
        end
        default: phase_next = PH_WAIT_LOW;
      endcase
    end
  end

  // measurement sequence
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (finish) state_next = S_MUL;
      S_MUL:   state_next = S_PREP;
      S_PREP:  state_next = S_DIV;
      S_DIV:   if (status.div_last) state_next = S_SAT;
      S_SAT:   state_next = S_SPLIT;
      S_SPLIT: if (status.split_last) state_next = S_EMIT;
      S_EMIT:  if (out_ready && status.pos_last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd.cnt_inc    = cnt_inc;
    cmd.mul_load   = state == S_MUL;
    cmd.div_init   = state == S_PREP;
    cmd.div_step   = state == S_DIV;
    cmd.sat_load   = state == S_SAT;
    cmd.split_step = state == S_SPLIT;
    cmd.emit_next  = (state == S_EMIT) && out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_WAIT_LOW;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  // input and output sides never open together
  `PFM7_ASSERT_NOW(a_ready_valid_excl, clk, rst, 1'b1, !(in_ready && out_valid),
    "input ready while a digit transaction is pending")
  // a high level in the low phase starts the arithmetic
  `PFM7_ASSERT_NEXT(a_finish_starts, clk, rst,
    in_fire && phase == PH_LOW && level, state == S_MUL && phase == PH_WAIT_LOW,
    "measurement end did not start the arithmetic")
  // the hundredths digit closes the run
  `PFM7_ASSERT_NEXT(a_last_returns_idle, clk, rst,
    out_valid && out_ready && status.pos_last, in_ready,
    "block not idle after the final digit")
  // no sample counted outside the idle state
  `PFM7_ASSERT_NOW(a_count_only_idle, clk, rst, cmd.cnt_inc, state == S_IDLE,
    "sample counted while busy")

endmodule
